FILE: design/conv3x3_padded_multichannel_assert.svh
// Assertion macros for the 3x3 convolution block.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef CONV3X3_PADDED_MULTICHANNEL_ASSERT_SVH
`define CONV3X3_PADDED_MULTICHANNEL_ASSERT_SVH

// Same-cycle implication.
`define C3PM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C3PM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/c3pm_pkg.sv
// Shared types and constants of the 3x3 convolution block.
// No dependencies.
package c3pm_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int COEF_W   = 16;
    localparam int FIELD_W  = 16;
    localparam int VALUE_W  = 40;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 5;
    localparam int NUM_W    = 27;
    localparam int NUM_B    = 3;
    localparam int CH       = 3;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_PIXEL  = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_BIAS   = 2'd2;
    localparam logic [1:0] KIND_PIXEL  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Tap selection for one window column cell.
    typedef struct packed {
        logic       dr;
        logic       dc;
        logic [2:0] kh_en;
        logic       kw_en;
    } cell_ctl_t;

endpackage

FILE: design/c3pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c3pm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/c3pm_cell.sv
// One window column cell: holds a three-row, three-channel column, shifts it to
// its left neighbor and forms the nine products of one kernel column. Uses c3pm_pkg.
module c3pm_cell #(
    parameter int SB = c3pm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  shift_en,
    input  logic [8:0][SB-1:0]                    col_in,
    output logic [8:0][SB-1:0]                    col_out,
    input  c3pm_pkg::cell_ctl_t                   ctl,
    input  logic [8:0][c3pm_pkg::COEF_W-1:0]      weights,
    input  logic                                  prod_en,
    input  logic                                  sum_en,
    output logic signed [SB+c3pm_pkg::COEF_W+3:0] sum_out
);

    localparam int PW   = SB + c3pm_pkg::COEF_W;
    localparam int SUMW = PW + 4;

    logic [8:0][SB-1:0]           col_reg;
    logic signed [PW-1:0]         prod_reg [9];
    logic signed [PW-1:0]         prod_next [9];
    logic signed [SUMW-1:0]       sum_reg;
    logic signed [SUMW-1:0]       sum_next;

    always_comb begin
        logic [2:0]           row;
        logic [8:0][SB-1:0]   src;
        logic signed [SB-1:0] tap;
        src = ctl.dc ? col_in : col_reg;
        for (int kh = 0; kh < 3; kh++) begin
            for (int ch = 0; ch < 3; ch++) begin
                row = 3'(kh) + {2'b00, ctl.dr};
                if (ctl.kh_en[kh] && ctl.kw_en && row < 3'd3) begin
                    tap = $signed(src[row[1:0] * 3 + ch]);
                end else begin
                    tap = '0;
                end
                prod_next[kh * 3 + ch] = tap * $signed(weights[kh * 3 + ch]);
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < 9; i++) begin
            sum_next = sum_next + SUMW'(prod_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        if (prod_en) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (sum_en) begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule

FILE: design/conv3x3_padded_multichannel.sv
// Channel   | beat when          | fields (lowest bit first)
// s_        | s_tvalid&s_tready  | tuser: operation; tdata: index, coef, ch0..ch2
// m_        | m_tvalid&m_tready  | tdata: value, row, column; tlast: frame end
// cfg_      | cfg_we             | cfg_index selects width or height
// One beat enters per cycle while each pixel yields at most one output and no
// m_ stall has filled the pipeline. A pixel yielding several outputs holds the
// window cell chain and the input until its last output is generated. Results
// pass the line RAM read, the product registers and the two adder stages. Reset
// is synchronous; no clearing pass. Pipeline registers absorb an m_ stall until full.
module conv3x3_padded_multichannel #(
    parameter int MAX_WIDTH   = c3pm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = c3pm_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = c3pm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // coef_index, coef_value, pixel_ch0, pixel_ch1, pixel_ch2, zero fill
    input  logic [c3pm_pkg::S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // conv_value, out_row, out_col, zero fill
    output logic [c3pm_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [c3pm_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PW    = SB + c3pm_pkg::COEF_W;
    localparam int SUMW  = PW + 4;
    localparam int SW    = (PW + 6 > c3pm_pkg::VALUE_W) ? PW + 6 : c3pm_pkg::VALUE_W;
    localparam int BW    = c3pm_pkg::COEF_W + 2;

    // Configuration and position.
    logic [c3pm_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [COL_W:0]             w_eff;
    logic [ROW_W:0]             h_eff;
    logic [12:0]                w_wide, h_wide, w_sat, h_sat;

    always_comb begin
        w_wide = 13'(width_reg);
        h_wide = 13'(height_reg);
        if (w_wide < 13'd2) begin
            w_sat = 13'd2;
        end else if (w_wide > 13'(MAX_WIDTH)) begin
            w_sat = 13'(MAX_WIDTH);
        end else begin
            w_sat = w_wide;
        end
        if (h_wide < 13'd2) begin
            h_sat = 13'd2;
        end else if (h_wide > 13'(MAX_HEIGHT)) begin
            h_sat = 13'(MAX_HEIGHT);
        end else begin
            h_sat = h_wide;
        end
        w_eff = (COL_W + 1)'(w_sat);
        h_eff = (ROW_W + 1)'(h_sat);
    end

    // Input decode.
    logic                       s_acc;
    logic [1:0]                 in_kind;
    logic [c3pm_pkg::IDX_W-1:0] in_idx;
    logic [c3pm_pkg::COEF_W-1:0] in_coef;
    logic [2:0][SB-1:0]         in_px;
    logic [31:0]                px_ext [3];
    logic [COL_W-1:0]           cc;
    logic [ROW_W-1:0]           rr;
    logic                       in_lc, in_lr;

    assign s_acc   = s_tvalid && s_tready;
    assign in_idx  = s_tdata[4:0];
    assign in_coef = s_tdata[20:5];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            px_ext[ch] = {16'b0, s_tdata[21 + 16 * ch +: 16]};
            in_px[ch]  = px_ext[ch][SB-1:0];
        end
        unique case (s_tuser)
            c3pm_pkg::OP_WEIGHT: in_kind = (in_idx < 5'(c3pm_pkg::NUM_W)) ?
                                           c3pm_pkg::KIND_WEIGHT : c3pm_pkg::KIND_NONE;
            c3pm_pkg::OP_BIAS:   in_kind = (in_idx < 5'(c3pm_pkg::NUM_B)) ?
                                           c3pm_pkg::KIND_BIAS : c3pm_pkg::KIND_NONE;
            c3pm_pkg::OP_PIXEL:  in_kind = c3pm_pkg::KIND_PIXEL;
            default:             in_kind = c3pm_pkg::KIND_NONE;
        endcase
        if ({1'b0, row_reg} >= h_eff || {1'b0, col_reg} >= w_eff) begin
            rr = '0;
            cc = '0;
        end else begin
            rr = row_reg;
            cc = col_reg;
        end
        in_lc = ({1'b0, cc} + 1'b1) == w_eff;
        in_lr = ({1'b0, rr} + 1'b1) == h_eff;
        if (in_lc) begin
            col_next = '0;
            row_next = in_lr ? '0 : rr + 1'b1;
        end else begin
            col_next = cc + 1'b1;
            row_next = rr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= c3pm_pkg::CFG_W'(5);
            height_reg <= c3pm_pkg::CFG_W'(5);
            row_reg    <= '0;
            col_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                c3pm_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                c3pm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:              width_reg  <= width_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_acc && in_kind == c3pm_pkg::KIND_PIXEL) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Fetch stage: line RAM read and write-back.
    logic                        f_valid, f_fresh, f_adv;
    logic [1:0]                  f_kind;
    logic [c3pm_pkg::IDX_W-1:0]  f_idx;
    logic [c3pm_pkg::COEF_W-1:0] f_coef;
    logic [2:0][SB-1:0]          f_px;
    logic [ROW_W-1:0]            f_r;
    logic [COL_W-1:0]            f_c;
    logic                        f_lc, f_lr;
    logic [6*SB-1:0]             ram_rdata, ram_wdata;
    logic [3*SB-1:0]             line_old, line_prev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid <= 1'b0;
            f_fresh <= 1'b0;
        end else begin
            f_fresh <= s_acc && in_kind == c3pm_pkg::KIND_PIXEL;
            if (s_tready) begin
                f_valid <= s_acc;
            end
        end
        if (s_acc) begin
            f_kind <= in_kind;
            f_idx  <= in_idx;
            f_coef <= in_coef;
            f_px   <= in_px;
            f_r    <= rr;
            f_c    <= cc;
            f_lc   <= in_lc;
            f_lr   <= in_lr;
        end
    end

    assign line_old  = f_r[0] ? ram_rdata[6*SB-1:3*SB] : ram_rdata[3*SB-1:0];
    assign line_prev = f_r[0] ? ram_rdata[3*SB-1:0] : ram_rdata[6*SB-1:3*SB];
    assign ram_wdata = f_r[0] ? {f_px, ram_rdata[3*SB-1:0]} : {ram_rdata[6*SB-1:3*SB], f_px};

    c3pm_ram #(.W(6 * SB), .D(MAX_WIDTH)) u_line (
        .aclk  (aclk),
        .we    (f_fresh),
        .waddr (f_c),
        .wdata (ram_wdata),
        .re    (s_acc && in_kind == c3pm_pkg::KIND_PIXEL),
        .raddr (cc),
        .rdata (ram_rdata)
    );

    // Output generator over the window.
    logic [3:0]           pend_reg, pend_next, sel, mask_new;
    logic [ROW_W-1:0]     g_r;
    logic [COL_W-1:0]     g_c;
    logic                 g_r1, g_c1;
    logic                 gen_fire, p_rdy, a_rdy, o_rdy;
    logic                 dr, dc;
    c3pm_pkg::cell_ctl_t  ctl [3];

    logic [c3pm_pkg::COEF_W-1:0] weight_reg [c3pm_pkg::NUM_W];
    logic [c3pm_pkg::COEF_W-1:0] bias_reg   [c3pm_pkg::NUM_B];

    assign mask_new[0] = (f_r != '0) && (f_c != '0);
    assign mask_new[1] = (f_r != '0) && f_lc;
    assign mask_new[2] = f_lr && (f_c != '0);
    assign mask_new[3] = f_lr && f_lc;

    always_comb begin
        priority if (pend_reg[0]) begin
            sel = 4'b0001;
        end else if (pend_reg[1]) begin
            sel = 4'b0010;
        end else if (pend_reg[2]) begin
            sel = 4'b0100;
        end else if (pend_reg[3]) begin
            sel = 4'b1000;
        end else begin
            sel = 4'b0000;
        end
        dr       = sel[2] || sel[3];
        dc       = sel[1] || sel[3];
        gen_fire = (pend_reg != 4'b0) && p_rdy;
        f_adv    = f_valid && ((pend_reg == 4'b0) || (gen_fire && (pend_reg & ~sel) == 4'b0));
        if (f_adv && f_kind == c3pm_pkg::KIND_PIXEL) begin
            pend_next = mask_new;
        end else if (gen_fire) begin
            pend_next = pend_reg & ~sel;
        end else begin
            pend_next = pend_reg;
        end
        for (int k = 0; k < 3; k++) begin
            ctl[k].dr    = dr;
            ctl[k].dc    = dc;
            ctl[k].kh_en = {~dr, 1'b1, ~(~dr && g_r1)};
        end
        ctl[0].kw_en = ~(~dc && g_c1);
        ctl[1].kw_en = 1'b1;
        ctl[2].kw_en = ~dc;
    end

    assign s_tready = !f_valid || f_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 4'b0;
            for (int i = 0; i < c3pm_pkg::NUM_W; i++) begin
                weight_reg[i] <= '0;
            end
            for (int i = 0; i < c3pm_pkg::NUM_B; i++) begin
                bias_reg[i] <= '0;
            end
        end else begin
            pend_reg <= pend_next;
            if (f_adv && f_kind == c3pm_pkg::KIND_WEIGHT) begin
                weight_reg[f_idx] <= f_coef;
            end
            if (f_adv && f_kind == c3pm_pkg::KIND_BIAS) begin
                bias_reg[f_idx[1:0]] <= f_coef;
            end
        end
        if (f_adv && f_kind == c3pm_pkg::KIND_PIXEL) begin
            g_r  <= f_r;
            g_c  <= f_c;
            g_r1 <= f_r == ROW_W'(1);
            g_c1 <= f_c == COL_W'(1);
        end
    end

    // Window cell chain, one cell per kernel column.
    logic [8:0][SB-1:0]          col_new;
    logic [8:0][SB-1:0]          col_link [3];
    logic [8:0][c3pm_pkg::COEF_W-1:0] cell_w [3];
    logic signed [SUMW-1:0]      cell_sum [3];
    logic                        shift_en;

    assign shift_en = f_adv && f_kind == c3pm_pkg::KIND_PIXEL;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            col_new[ch]     = line_old[ch * SB +: SB];
            col_new[3 + ch] = line_prev[ch * SB +: SB];
            col_new[6 + ch] = f_px[ch];
        end
        for (int kw = 0; kw < 3; kw++) begin
            for (int kh = 0; kh < 3; kh++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    cell_w[kw][kh * 3 + ch] = weight_reg[ch * 9 + kh * 3 + kw];
                end
            end
        end
    end

    for (genvar kw = 0; kw < 3; kw++) begin : g_cell
        logic [8:0][SB-1:0] shift_src;
        if (kw == 2) begin : g_head
            assign shift_src = col_new;
        end else begin : g_body
            assign shift_src = col_link[kw + 1];
        end
        c3pm_cell #(.SB(SB)) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .col_in   (shift_src),
            .col_out  (col_link[kw]),
            .ctl      (ctl[kw]),
            .weights  (cell_w[kw]),
            .prod_en  (p_rdy),
            .sum_en   (a_rdy),
            .sum_out  (cell_sum[kw])
        );
    end

    // Product and accumulate stage bookkeeping.
    logic                   p_valid, a_valid;
    logic [c3pm_pkg::POS_W-1:0] p_row, p_col, a_row, a_col;
    logic                   p_end, a_end;
    logic signed [BW-1:0]   p_bias, a_bias;
    logic [31:0]            orow_ext, ocol_ext;
    logic signed [SW-1:0]   total;

    assign o_rdy = !m_tvalid || m_tready;
    assign a_rdy = !a_valid || o_rdy;
    assign p_rdy = !p_valid || a_rdy;

    assign orow_ext = 32'(g_r) + 32'(dr) - 32'd1;
    assign ocol_ext = 32'(g_c) + 32'(dc) - 32'd1;
    assign total = SW'(cell_sum[0]) + SW'(cell_sum[1]) + SW'(cell_sum[2]) + SW'(a_bias);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid  <= 1'b0;
            a_valid  <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (p_rdy) begin
                p_valid <= gen_fire;
            end
            if (a_rdy) begin
                a_valid <= p_valid;
            end
            if (o_rdy) begin
                m_tvalid <= a_valid;
            end
        end
        if (p_rdy) begin
            p_row  <= orow_ext[c3pm_pkg::POS_W-1:0];
            p_col  <= ocol_ext[c3pm_pkg::POS_W-1:0];
            p_end  <= sel[3];
            p_bias <= BW'($signed(bias_reg[0])) + BW'($signed(bias_reg[1]))
                    + BW'($signed(bias_reg[2]));
        end
        if (a_rdy) begin
            a_row  <= p_row;
            a_col  <= p_col;
            a_end  <= p_end;
            a_bias <= p_bias;
        end
        if (o_rdy) begin
            m_tdata <= {4'b0, a_col, a_row, total[c3pm_pkg::VALUE_W-1:0]};
            m_tlast <= a_end;
        end
    end

`include "conv3x3_padded_multichannel_assert.svh"

    `C3PM_ASSERT_NOW(a_single_left, f_adv, pend_reg == 4'b0 || $onehot(pend_reg), "fetch stage advanced over several pending outputs")
    `C3PM_ASSERT_NOW(a_corner_full, shift_en && mask_new[3], mask_new == 4'b1111, "frame corner pixel without all four outputs")
    `C3PM_ASSERT_NXT(a_fire_lands, gen_fire, p_valid, "generated output missing from product stage")

endmodule

FILE: bench/conv3x3_padded_multichannel_tb.sv
// Self-checking testbench for conv3x3_padded_multichannel.
// Drives weight, bias and pixel beats, predicts every output in SystemVerilog
// and compares it field by field; depends on c3pm_pkg and the block itself.
`timescale 1ns / 100ps

module conv3x3_padded_multichannel_tb;
    import c3pm_pkg::*;

    typedef struct packed {
        logic [39:0] val;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        last;
    } conv_out_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [4:0]         idx;
        logic signed [15:0] coef;
        logic signed [15:0] p0;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic               typed;
        logic [39:0]        exp_val;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = OP_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]      cfg_data = '0;

    conv3x3_padded_multichannel u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state.
    logic [10:0]        img_w_raw, img_h_raw;
    int                 in_row, in_col;
    logic signed [15:0] wt_mem [27];
    logic signed [15:0] bias_mem [3];
    logic signed [15:0] line_mem [2048][3];
    logic signed [15:0] win [3][3][3];

    conv_out_t pending_outs [$];
    conv_out_t got_out;
    conv_out_t exp_out;
    int        errors = 0;
    int        pixels_sent = 0;
    int        outs_checked = 0;
    int        frames_done = 0;
    int        s_idle_pct = 0;
    int        m_idle_pct = 0;
    int        hold_left = 0;
    bit        hold_go = 1'b0;
    stim_row_t dir_tab [19];

    function automatic int sat_size(logic [10:0] v);
        if (v < 2) return 2;
        if (v > 1024) return 1024;
        return int'(v);
    endfunction

    function automatic logic [39:0] conv_at(int r, int c, int orow, int ocol, int w, int h);
        longint s;
        int     ir, ic, wi, wj;
        s = 0;
        for (int kh = 0; kh < 3; kh++)
            for (int kw = 0; kw < 3; kw++) begin
                ir = orow - 1 + kh;
                ic = ocol - 1 + kw;
                wi = ir - (r - 2);
                wj = ic - (c - 2);
                if (ir >= 0 && ir < h && ic >= 0 && ic < w && wi >= 0 && wi <= 2
                        && wj >= 0 && wj <= 2)
                    for (int ch = 0; ch < 3; ch++)
                        s += longint'(win[wi][wj][ch]) * longint'(wt_mem[ch*9 + kh*3 + kw]);
            end
        s += longint'(bias_mem[0]) + longint'(bias_mem[1]) + longint'(bias_mem[2]);
        return s[39:0];
    endfunction

    task automatic emit_out(logic [39:0] v, int row, int col, bit last, bit ovr,
                            logic [39:0] ovr_val);
        conv_out_t o;
        o.val  = ovr ? ovr_val : v;
        o.row  = row[9:0];
        o.col  = col[9:0];
        o.last = last;
        pending_outs.push_back(o);
    endtask

    task automatic apply_beat(logic [1:0] op, logic [4:0] idx, logic signed [15:0] cv,
                              logic signed [15:0] p0, logic signed [15:0] p1,
                              logic signed [15:0] p2, bit ovr, logic [39:0] ovr_val);
        int                 w, h, r, c, old_s, prev_s;
        logic signed [15:0] px [3];
        px[0] = p0;
        px[1] = p1;
        px[2] = p2;
        case (op)
            OP_WEIGHT: if (idx < NUM_W) wt_mem[idx] = cv;
            OP_BIAS:   if (idx < NUM_B) bias_mem[idx] = cv;
            OP_PIXEL: begin
                w = sat_size(img_w_raw);
                h = sat_size(img_h_raw);
                r = in_row;
                c = in_col;
                if (r >= h || c >= w) begin
                    r = 0;
                    c = 0;
                end
                old_s  = (r & 1) * 1024 + (c % 1024);
                prev_s = ((r + 1) & 1) * 1024 + (c % 1024);
                for (int i = 0; i < 3; i++)
                    for (int ch = 0; ch < 3; ch++) begin
                        win[i][0][ch] = win[i][1][ch];
                        win[i][1][ch] = win[i][2][ch];
                    end
                for (int ch = 0; ch < 3; ch++) begin
                    win[0][2][ch] = line_mem[old_s][ch];
                    win[1][2][ch] = line_mem[prev_s][ch];
                    win[2][2][ch] = px[ch];
                    line_mem[old_s][ch] = px[ch];
                end
                if (r >= 1 && c >= 1)
                    emit_out(conv_at(r, c, r-1, c-1, w, h), r-1, c-1, 0, ovr, ovr_val);
                if (r >= 1 && c == w-1)
                    emit_out(conv_at(r, c, r-1, c, w, h), r-1, c, 0, ovr, ovr_val);
                if (r == h-1 && c >= 1)
                    emit_out(conv_at(r, c, r, c-1, w, h), r, c-1, 0, ovr, ovr_val);
                if (r == h-1 && c == w-1) begin
                    emit_out(conv_at(r, c, r, c, w, h), r, c, 1, ovr, ovr_val);
                    frames_done++;
                end
                c++;
                if (c >= w) begin
                    c = 0;
                    r++;
                    if (r >= h) r = 0;
                end
                in_row = r;
                in_col = c;
                pixels_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(logic [1:0] op, logic [4:0] idx, logic signed [15:0] cv,
                             logic signed [15:0] p0, logic signed [15:0] p1,
                             logic signed [15:0] p2, bit ovr = 0, logic [39:0] ovr_val = '0);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, p2, p1, p0, cv, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_beat(op, idx, cv, p0, p1, p2, ovr, ovr_val);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH) img_w_raw = val;
        else img_h_raw = val;
        in_row = 0;
        in_col = 0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 19))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh0000;
            3: return -16'sh0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_coefs();
        for (int i = 0; i < NUM_W; i++)
            send_beat(OP_WEIGHT, 5'(i), rand_sample(), 0, 0, 0);
        for (int i = 0; i < NUM_B; i++)
            send_beat(OP_BIAS, 5'(i), rand_sample(), 0, 0, 0);
    endtask

    task automatic send_pixels(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 2)
                send_beat(2'd3, 5'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            else if (k < 4)
                send_beat(OP_WEIGHT, 5'($urandom_range(27, 31)), rand_sample(), 0, 0, 0);
            else if (k < 5)
                send_beat(OP_BIAS, 5'($urandom_range(3, 31)), rand_sample(), 0, 0, 0);
            else if (k < 7)
                send_beat(OP_WEIGHT, 5'($urandom_range(0, 26)), rand_sample(), 0, 0, 0);
            else if (k < 8)
                send_beat(OP_BIAS, 5'($urandom_range(0, 2)), rand_sample(), 0, 0, 0);
            send_beat(OP_PIXEL, 5'($urandom), 16'($urandom),
                      rand_sample(), rand_sample(), rand_sample());
        end
    endtask

    task automatic run_size(logic [10:0] w, logic [10:0] h, int nfr);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        load_coefs();
        send_pixels(nfr * sat_size(w) * sat_size(h));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_out.val  = m_tdata[39:0];
            got_out.row  = m_tdata[49:40];
            got_out.col  = m_tdata[59:50];
            got_out.last = m_tlast;
            if (pending_outs.size() == 0) begin
                report_mismatch("output beat with nothing expected", 0, got_out.val);
            end else begin
                exp_out = pending_outs.pop_front();
                outs_checked++;
                if (got_out.val !== exp_out.val)
                    report_mismatch("conv_value", exp_out.val, got_out.val);
                if (got_out.row !== exp_out.row)
                    report_mismatch("out_row", exp_out.row, got_out.row);
                if (got_out.col !== exp_out.col)
                    report_mismatch("out_col", exp_out.col, got_out.col);
                if (got_out.last !== exp_out.last)
                    report_mismatch("frame_end", exp_out.last, got_out.last);
                if (m_tdata[63:60] !== 4'b0000)
                    report_mismatch("tdata fill", 0, m_tdata[63:60]);
            end
        end
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    task automatic report_mismatch(string what, logic [39:0] exp_v, logic [39:0] got_v);
        $display("MISMATCH %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    initial begin
        #2_000_000;
        $display("conv3x3_padded_multichannel test failed");
        $finish;
    end

    initial begin
        img_w_raw = 11'd5;
        img_h_raw = 11'd5;
        in_row = 0;
        in_col = 0;
        foreach (wt_mem[i]) wt_mem[i] = '0;
        foreach (bias_mem[i]) bias_mem[i] = '0;
        foreach (win[i, j, k]) win[i][j][k] = '0;
        foreach (line_mem[i, k]) line_mem[i][k] = '0;

        dir_tab = '{
            '{OP_PIXEL,  5'd0,  16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd31, 16'shffff, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, 16'sh5555, 16'sh5555, 16'sh5555, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, -16'sh5556, -16'sh5556, -16'sh5556, 1'b1, 40'd0},
            '{OP_WEIGHT, 5'd0,  16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_WEIGHT, 5'd26, -16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_WEIGHT, 5'd13, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_WEIGHT, 5'd27, 16'sh0005, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_WEIGHT, 5'd31, 16'shffff, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_BIAS,   5'd0,  -16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_BIAS,   5'd2,  16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_BIAS,   5'd3,  16'sh0064, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{OP_BIAS,   5'd31, 16'sh1234, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0},
            '{2'd3,      5'd31, 16'shffff, -16'sh0001, -16'sh0001, -16'sh0001, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, 16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0, 40'd0},
            '{OP_PIXEL,  5'd0,  16'sh0000, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0, 40'd0},
            '{OP_BIAS,   5'd1,  16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 40'd0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_HEIGHT, 11'd2);
        foreach (dir_tab[i])
            send_beat(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].coef, dir_tab[i].p0,
                      dir_tab[i].p1, dir_tab[i].p2, dir_tab[i].typed, dir_tab[i].exp_val);

        for (int ph = 0; ph < 3; ph++) begin
            s_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 69 : 0;
            m_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 31 : 0;
            for (int n = 0; n < 7; n++)
                run_size(11'($urandom_range(2, 6)), 11'($urandom_range(2, 5)),
                         $urandom_range(1, 2));
            if (ph == 2) begin
                write_reg(REG_WIDTH, 11'd8);
                write_reg(REG_HEIGHT, 11'd8);
                hold_go = 1'b1;
                send_pixels(64);
                // Partial frame, then a register write restarts the raster.
                write_reg(REG_WIDTH, 11'd4);
                write_reg(REG_HEIGHT, 11'd4);
                send_pixels(16 + 6);
                write_reg(REG_HEIGHT, 11'd3);
                send_pixels(12);
                run_size(11'd0, 11'd0, 1);
                run_size(11'd2047, 11'd2, 1);
                run_size(11'd2, 11'd2047, 1);
                run_size(11'd1024, 11'd1024 - 11'd1022, 1);
            end
        end

        drain();
        $display("Covered %0d pixel beats, %0d checked outputs, %0d frames,",
                 pixels_sent, outs_checked, frames_done);
        $display("sizes from 2x2 to 1024 wide and tall, coefficient loads and stalls.");
        if (errors == 0) begin
            $display("conv3x3_padded_multichannel test passed");
        end else begin
            $display("conv3x3_padded_multichannel test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/c3pm_pkg.sv
design/c3pm_ram.sv
design/c3pm_cell.sv
design/conv3x3_padded_multichannel.sv
bench/conv3x3_padded_multichannel_tb.sv
